>>> rtl/core/mtb_pkg.sv
// Shared types and constants for the morph-target trilinear blend.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package mtb_pkg;

  // Default sizes of the datapath.
  localparam int COORD_WIDTH_DEF      = 32;
  localparam int WEIGHT_FRAC_BITS_DEF = 16;

  // Fixed sizes of the register file and the item fields.
  localparam int REG_WIDTH       = 17;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int NUM_AXES        = 3;
  localparam int AXIS_WIDTH      = 2;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_STRENGTH  = 2'd0,
    REG_DEXTERITY = 2'd1,
    REG_SCALE     = 2'd2
  } reg_index_t;

  // Kind of an item.
  typedef enum logic {
    KIND_VERTEX = 1'b0,
    KIND_OFFSET = 1'b1
  } item_kind_t;

  // Axis codes.
  localparam logic [AXIS_WIDTH-1:0] AXIS_X = 2'd0;
  localparam logic [AXIS_WIDTH-1:0] AXIS_Y = 2'd1;
  localparam logic [AXIS_WIDTH-1:0] AXIS_Z = 2'd2;

  // Side information that travels with each word through the pipeline.
  typedef struct packed {
    logic [AXIS_WIDTH-1:0] axis;
    item_kind_t            kind;
  } tag_t;

endpackage

`default_nettype wire

>>> rtl/core/mtb_if.sv
// Valid/ready channel interfaces for the blend input and result words.
// Depends on mtb_pkg for the field widths.
`default_nettype none

interface mtb_in_if
  import mtb_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
  logic                   valid;
  logic                   ready;
  logic [COORD_WIDTH-1:0] corner_0;
  logic [COORD_WIDTH-1:0] corner_1;
  logic [COORD_WIDTH-1:0] corner_2;
  logic [COORD_WIDTH-1:0] corner_3;
  logic [COORD_WIDTH-1:0] corner_4;
  logic [COORD_WIDTH-1:0] corner_5;
  logic [COORD_WIDTH-1:0] corner_6;
  logic [COORD_WIDTH-1:0] corner_7;
  logic [AXIS_WIDTH-1:0]  axis;
  logic                   item_kind;

  modport source (
    output valid, corner_0, corner_1, corner_2, corner_3,
           corner_4, corner_5, corner_6, corner_7, axis, item_kind,
    input  ready
  );

  modport sink (
    input  valid, corner_0, corner_1, corner_2, corner_3,
           corner_4, corner_5, corner_6, corner_7, axis, item_kind,
    output ready
  );
endinterface

interface mtb_out_if
  import mtb_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
  logic                   valid;
  logic                   ready;
  logic [COORD_WIDTH-1:0] blended_value;
  logic [AXIS_WIDTH-1:0]  result_axis;
  logic                   result_kind;
  logic                   saturated;

  modport source (
    output valid, blended_value, result_axis, result_kind, saturated,
    input  ready
  );

  modport sink (
    input  valid, blended_value, result_axis, result_kind, saturated,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/core/morph_target_trilinear_blend_top.sv
// Morph-target trilinear blend: top level.
// Depends on mtb_pkg, mtb_if, mtb_weights, mtb_lerp and mtb_out.
//
// Usage:
//   The corners channel takes one word per item: eight corner coordinates of
//   one axis, the axis code and the item kind. The results channel returns one
//   word per item, in order. Weights are written through cfg_we, cfg_index and
//   cfg_data while no item is in flight.
//   Corner pairs are blended by the dexterity weight, the row pairs by the
//   strength weight and the halves by the scale weight; each blend is three
//   register stages (difference, product, shifted add). A tenth register stage
//   adds the stored offset, saturates, and holds the result word.
//   Throughput: one item per cycle while the receiver does not stall; the
//   multiplier of each blend is combinational, ahead of its product register.
//   Offset items store their blend when they reach the output stage.
//   Reset clears the weights, the stored offsets and all valid bits.
//   When the receiver stalls, the output word holds and each stage fills in
//   turn; corners.ready falls only once every stage holds a word.
`default_nettype none

module morph_target_trilinear_blend_top
  import mtb_pkg::*;
#(
  parameter int COORD_WIDTH      = COORD_WIDTH_DEF,
  parameter int WEIGHT_FRAC_BITS = WEIGHT_FRAC_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [REG_WIDTH-1:0]       cfg_data,
  mtb_in_if.sink                          corners,
  mtb_out_if.source                       results
);

  logic [WEIGHT_FRAC_BITS:0] w_strength;
  logic [WEIGHT_FRAC_BITS:0] w_dexterity;
  logic [WEIGHT_FRAC_BITS:0] w_scale;

  logic [3:0][COORD_WIDTH-1:0] pair_a, pair_b, pair_y;
  logic [1:0][COORD_WIDTH-1:0] row_a, row_b, row_y;
  logic [0:0][COORD_WIDTH-1:0] half_y;
  tag_t                        in_tag, pair_tag, row_tag, half_tag;
  logic                        pair_valid, pair_ready;
  logic                        row_valid, row_ready;
  logic                        half_valid, half_ready;

  // Weight registers.
  mtb_weights #(
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
  ) u_weights (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .w_strength  (w_strength),
    .w_dexterity (w_dexterity),
    .w_scale     (w_scale)
  );

  // Adjacent corners form the pairs of the first blend.
  assign pair_a[0] = corners.corner_0;
  assign pair_b[0] = corners.corner_1;
  assign pair_a[1] = corners.corner_2;
  assign pair_b[1] = corners.corner_3;
  assign pair_a[2] = corners.corner_4;
  assign pair_b[2] = corners.corner_5;
  assign pair_a[3] = corners.corner_6;
  assign pair_b[3] = corners.corner_7;
  assign in_tag.axis = corners.axis;
  assign in_tag.kind = item_kind_t'(corners.item_kind);

  mtb_lerp #(
    .COORD_WIDTH      (COORD_WIDTH),
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS),
    .LANES            (4)
  ) u_pairs (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (corners.valid),
    .in_ready  (corners.ready),
    .a         (pair_a),
    .b         (pair_b),
    .in_tag    (in_tag),
    .weight    (w_dexterity),
    .out_valid (pair_valid),
    .out_ready (pair_ready),
    .y         (pair_y),
    .out_tag   (pair_tag)
  );

  // Row blend: low half from pairs 0 and 1, high half from pairs 2 and 3.
  assign row_a[0] = pair_y[0];
  assign row_b[0] = pair_y[1];
  assign row_a[1] = pair_y[2];
  assign row_b[1] = pair_y[3];

  mtb_lerp #(
    .COORD_WIDTH      (COORD_WIDTH),
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS),
    .LANES            (2)
  ) u_rows (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pair_valid),
    .in_ready  (pair_ready),
    .a         (row_a),
    .b         (row_b),
    .in_tag    (pair_tag),
    .weight    (w_strength),
    .out_valid (row_valid),
    .out_ready (row_ready),
    .y         (row_y),
    .out_tag   (row_tag)
  );

  // Final blend of the two halves.
  mtb_lerp #(
    .COORD_WIDTH      (COORD_WIDTH),
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS),
    .LANES            (1)
  ) u_halves (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (row_valid),
    .in_ready  (row_ready),
    .a         (row_y[0:0]),
    .b         (row_y[1:1]),
    .in_tag    (row_tag),
    .weight    (w_scale),
    .out_valid (half_valid),
    .out_ready (half_ready),
    .y         (half_y),
    .out_tag   (half_tag)
  );

  // Offset add and result register.
  mtb_out #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_out (
    .clk      (clk),
    .rst      (rst),
    .in_valid (half_valid),
    .in_ready (half_ready),
    .value    (half_y[0]),
    .in_tag   (half_tag),
    .results  (results)
  );

endmodule

`default_nettype wire

>>> rtl/core/mtb_weights.sv
// Blend weight registers with the clamp to one applied on the way out.
// Depends on mtb_pkg for the register indexes and widths.
`default_nettype none

module mtb_weights
  import mtb_pkg::*;
#(
  parameter int WEIGHT_FRAC_BITS = WEIGHT_FRAC_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [REG_WIDTH-1:0]       cfg_data,
  output logic [WEIGHT_FRAC_BITS:0]       w_strength,
  output logic [WEIGHT_FRAC_BITS:0]       w_dexterity,
  output logic [WEIGHT_FRAC_BITS:0]       w_scale
);

  localparam int WW   = WEIGHT_FRAC_BITS + 1;
  localparam int CMPW = (WW > REG_WIDTH) ? WW : REG_WIDTH;
  localparam logic [CMPW-1:0] ONE = CMPW'(1) << WEIGHT_FRAC_BITS;

  logic [REG_WIDTH-1:0] strength;
  logic [REG_WIDTH-1:0] dexterity;
  logic [REG_WIDTH-1:0] scale;

  // A register value above one is used as exactly one.
  function automatic logic [WW-1:0] clamp_one(input logic [REG_WIDTH-1:0] r);
    logic [CMPW-1:0] x;
    x = CMPW'(r);
    if (x > ONE) begin
      x = ONE;
    end
    return x[WW-1:0];
  endfunction

  // Register writes; indexes past the last register are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      strength  <= '0;
      dexterity <= '0;
      scale     <= '0;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_STRENGTH:  strength  <= cfg_data;
        REG_DEXTERITY: dexterity <= cfg_data;
        REG_SCALE:     scale     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign w_strength  = clamp_one(strength);
  assign w_dexterity = clamp_one(dexterity);
  assign w_scale     = clamp_one(scale);

endmodule

`default_nettype wire

>>> rtl/core/mtb_lerp.sv
// Three-stage linear blend of LANES value pairs by one weight, with flow control.
// Depends on mtb_pkg for the tag type carried beside the data.
`default_nettype none

module mtb_lerp
  import mtb_pkg::*;
#(
  parameter int COORD_WIDTH      = COORD_WIDTH_DEF,
  parameter int WEIGHT_FRAC_BITS = WEIGHT_FRAC_BITS_DEF,
  parameter int LANES            = 1
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [LANES-1:0][COORD_WIDTH-1:0]   a,
  input  wire logic [LANES-1:0][COORD_WIDTH-1:0]   b,
  input  wire tag_t                                in_tag,
  input  wire logic [WEIGHT_FRAC_BITS:0]           weight,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [LANES-1:0][COORD_WIDTH-1:0]        y,
  output tag_t                                     out_tag
);

  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = COORD_WIDTH + WEIGHT_FRAC_BITS + 2;

  // Stage registers: difference, product, blended value.
  logic                                v1, v2, v3;
  logic [LANES-1:0][COORD_WIDTH-1:0]   a1, a2, y3;
  logic [LANES-1:0][DW-1:0]            d1;
  logic [LANES-1:0][PW-1:0]            p2;
  tag_t                                t1, t2, t3;

  logic [LANES-1:0][DW-1:0]            d_next;
  logic [LANES-1:0][PW-1:0]            p_next;
  logic [LANES-1:0][COORD_WIDTH-1:0]   y_next;
  logic                                r1, r2, r3;

  // A stage takes a new word when it is empty or its word moves on.
  assign r3       = !v3 || out_ready;
  assign r2       = !v2 || r3;
  assign r1       = !v1 || r2;
  assign in_ready = r1;

  // Difference b - a, one bit wider than the coordinates.
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      d_next[i] = {b[i][COORD_WIDTH-1], b[i]} - {a[i][COORD_WIDTH-1], a[i]};
    end
  end

  // Signed difference times the unsigned weight.
  always_comb begin
    logic signed [PW-1:0] de;
    logic signed [PW-1:0] we;
    for (int i = 0; i < LANES; i++) begin
      de        = PW'($signed(d1[i]));
      we        = PW'({1'b0, weight});
      p_next[i] = de * we;
    end
  end

  // Floor shift of the product, then add back the first value; the sum
  // lies between the two inputs, so the low bits are exact.
  always_comb begin
    logic signed [PW-1:0] sh;
    for (int i = 0; i < LANES; i++) begin
      sh        = $signed(p2[i]) >>> WEIGHT_FRAC_BITS;
      y_next[i] = a2[i] + sh[COORD_WIDTH-1:0];
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (r1) v1 <= in_valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (r1) begin
      a1 <= a;
      d1 <= d_next;
      t1 <= in_tag;
    end
    if (r2) begin
      a2 <= a1;
      p2 <= p_next;
      t2 <= t1;
    end
    if (r3) begin
      y3 <= y_next;
      t3 <= t2;
    end
  end

  assign out_valid = v3;
  assign y         = y3;
  assign out_tag   = t3;

endmodule

`default_nettype wire

>>> rtl/core/mtb_out.sv
// Offset store, offset add with saturation, and the result output register.
// Depends on mtb_pkg and the result channel interface in mtb_if.
`default_nettype none

module mtb_out
  import mtb_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [COORD_WIDTH-1:0] value,
  input  wire tag_t                   in_tag,
  mtb_out_if.source                   results
);

  localparam logic [COORD_WIDTH-1:0] MAX_VAL = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic [COORD_WIDTH-1:0] MIN_VAL = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  logic [COORD_WIDTH-1:0] offsets [NUM_AXES];
  logic [COORD_WIDTH-1:0] off;
  logic [COORD_WIDTH:0]   sum;
  logic [COORD_WIDTH-1:0] value_next;
  logic                   sat_next;
  logic                   load;

  assign in_ready = !results.valid || results.ready;
  assign load     = in_valid && in_ready;

  // Stored offset of this word's axis; the unused axis code adds zero.
  always_comb begin
    case (in_tag.axis)
      AXIS_X:  off = offsets[AXIS_X];
      AXIS_Y:  off = offsets[AXIS_Y];
      AXIS_Z:  off = offsets[AXIS_Z];
      default: off = '0;
    endcase
  end

  // Vertex words add the offset and clamp; offset words pass unchanged.
  always_comb begin
    sum = {value[COORD_WIDTH-1], value} + {off[COORD_WIDTH-1], off};
    if (in_tag.kind == KIND_OFFSET) begin
      value_next = value;
      sat_next   = 1'b0;
    end else if (sum[COORD_WIDTH] != sum[COORD_WIDTH-1]) begin
      value_next = sum[COORD_WIDTH] ? MIN_VAL : MAX_VAL;
      sat_next   = 1'b1;
    end else begin
      value_next = sum[COORD_WIDTH-1:0];
      sat_next   = 1'b0;
    end
  end

  // Offset words store their blend when they leave the pipeline, so later
  // vertex words of the same axis see it in order.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        offsets[i] <= '0;
      end
    end else if (load && in_tag.kind == KIND_OFFSET) begin
      case (in_tag.axis)
        AXIS_X:  offsets[AXIS_X] <= value;
        AXIS_Y:  offsets[AXIS_Y] <= value;
        AXIS_Z:  offsets[AXIS_Z] <= value;
        default: ;
      endcase
    end
  end

  // Output valid bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (in_ready) begin
      results.valid <= in_valid;
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (load) begin
      results.blended_value <= value_next;
      results.result_axis   <= in_tag.axis;
      results.result_kind   <= in_tag.kind;
      results.saturated     <= sat_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/mtb_checker.sv
// Port-level checks for the morph-target trilinear blend, bound to the top.
// Depends on mtb_pkg; sees only the top level's ports.
`default_nettype none

module mtb_checker
  import mtb_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   out_valid,
  input wire logic                   out_ready,
  input wire logic [COORD_WIDTH-1:0] blended_value,
  input wire logic                   result_kind,
  input wire logic                   saturated
);

  localparam logic [COORD_WIDTH-1:0] MAX_VAL = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic [COORD_WIDTH-1:0] MIN_VAL = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  // No result word directly after reset.
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result word valid right after reset");

  // A stalled result word holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(blended_value) && $stable(saturated))
    else $error("stalled result word changed");

  // Stored offsets never report saturation.
  a_offset_no_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind |-> !saturated)
    else $error("offset result flagged as saturated");

  // A saturated word sits on one of the two limits.
  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> (blended_value == MAX_VAL || blended_value == MIN_VAL))
    else $error("saturated word is not at a limit");

endmodule

bind morph_target_trilinear_blend_top mtb_checker #(
  .COORD_WIDTH (COORD_WIDTH)
) u_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (results.valid),
  .out_ready     (results.ready),
  .blended_value (results.blended_value),
  .result_kind   (results.result_kind),
  .saturated     (results.saturated)
);

`default_nettype wire

>>> sim/morph_target_trilinear_blend_top_tb.sv
// Self-checking testbench for morph_target_trilinear_blend_top: a directed table,
// then random phases with fresh weights, checked against written or predicted results.
// Depends on mtb_pkg, the mtb_in_if/mtb_out_if interfaces and the top-level RTL.

module morph_target_trilinear_blend_top_tb
  import mtb_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CYCLE_LIMIT  = 200000;
  localparam int          DRAIN_CYCLES = 12;
  localparam int          IDLE_PERCENT = 34;
  localparam int          RANDOM_PHASES = 6;
  localparam int          PHASE_WORDS  = 275;
  localparam logic [REG_WIDTH-1:0] WEIGHT_ZERO = '0;
  localparam logic [REG_WIDTH-1:0] WEIGHT_ONE  = REG_WIDTH'(1) << WEIGHT_FRAC_BITS_DEF;
  localparam logic [REG_WIDTH-1:0] WEIGHT_HALF = WEIGHT_ONE >> 1;
  localparam logic [REG_WIDTH-1:0] WEIGHT_TOP  = '1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE = 2'd3;
  localparam logic [AXIS_WIDTH-1:0] AXIS_NONE = 2'd3;
  localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;
  localparam longint SUM_MAX = (64'sd1 <<< (COORD_WIDTH_DEF - 1)) - 64'sd1;
  localparam longint SUM_MIN = -SUM_MAX - 64'sd1;

  typedef struct packed {
    logic [7:0][31:0]      corner;
    logic [AXIS_WIDTH-1:0] axis;
    item_kind_t            kind;
  } corner_word_t;

  typedef struct packed {
    logic [31:0]           value;
    logic [AXIS_WIDTH-1:0] axis;
    item_kind_t            kind;
    logic                  sat;
  } result_word_t;

  // A word waiting to be sent, with an optional hand-written expectation.
  typedef struct packed {
    corner_word_t word;
    logic         fixed;
    result_word_t want;
  } pending_word_t;

  typedef struct {
    logic [REG_WIDTH-1:0] ws;
    logic [REG_WIDTH-1:0] wd;
    logic [REG_WIDTH-1:0] wz;
    pending_word_t        entry;
  } directed_row_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_we = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = REG_STRENGTH;
  logic [REG_WIDTH-1:0]       cfg_data = '0;

  mtb_in_if  corners_if ();
  mtb_out_if results_if ();

  morph_target_trilinear_blend_top uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .corners   (corners_if),
    .results   (results_if)
  );

  // Shadow copy of the weight registers and the stored offsets.
  logic [REG_WIDTH-1:0] strength_reg = '0;
  logic [REG_WIDTH-1:0] dexterity_reg = '0;
  logic [REG_WIDTH-1:0] scale_reg = '0;
  longint               offset_by_axis [NUM_AXES] = '{default: 0};

  pending_word_t send_q[$];
  result_word_t  blend_results_q[$];
  directed_row_t directed_q[$];
  pending_word_t on_bus;
  bit            steady_run = 1'b0;
  int            fail_count = 0;
  int            result_count = 0;
  int            cycle_count = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Weights above one act as exactly one.
  function automatic longint weight_value(logic [REG_WIDTH-1:0] r);
    longint w;
    w = longint'(r);
    return (w > longint'(WEIGHT_ONE)) ? longint'(WEIGHT_ONE) : w;
  endfunction

  // a + floor((b - a) * w / 2^frac); the arithmetic shift gives the floor.
  function automatic longint mix_toward(longint a, longint b, longint w);
    longint p;
    p = (b - a) * w;
    return a + (p >>> WEIGHT_FRAC_BITS_DEF);
  endfunction

  // Blend one word, update the offset store and form its result.
  function automatic result_word_t predict_blend(corner_word_t w);
    longint       c [8];
    longint       ws, wd, wz, lo, hi, blend, sum;
    result_word_t r;
    ws = weight_value(strength_reg);
    wd = weight_value(dexterity_reg);
    wz = weight_value(scale_reg);
    for (int i = 0; i < 8; i++) c[i] = longint'($signed(w.corner[i]));
    lo = mix_toward(mix_toward(c[0], c[1], wd), mix_toward(c[2], c[3], wd), ws);
    hi = mix_toward(mix_toward(c[4], c[5], wd), mix_toward(c[6], c[7], wd), ws);
    blend = mix_toward(lo, hi, wz);
    r.axis = w.axis;
    r.kind = w.kind;
    r.sat = 1'b0;
    if (w.kind == KIND_OFFSET) begin
      if (w.axis != AXIS_NONE) offset_by_axis[w.axis] = blend;
      sum = blend;
    end else begin
      sum = blend + ((w.axis != AXIS_NONE) ? offset_by_axis[w.axis] : 64'sd0);
      if (sum > SUM_MAX) begin
        sum = SUM_MAX;
        r.sat = 1'b1;
      end else if (sum < SUM_MIN) begin
        sum = SUM_MIN;
        r.sat = 1'b1;
      end
    end
    r.value = sum[31:0];
    return r;
  endfunction

  // Even corners take a, odd corners take b: weight zero picks a, weight one picks b.
  function automatic pending_word_t make_word(logic [31:0] a, logic [31:0] b,
                                              logic [AXIS_WIDTH-1:0] axis,
                                              item_kind_t kind);
    pending_word_t p;
    for (int i = 0; i < 8; i++) p.word.corner[i] = i[0] ? b : a;
    p.word.axis = axis;
    p.word.kind = kind;
    p.fixed = 1'b0;
    p.want = '0;
    return p;
  endfunction

  task automatic add_row(logic [REG_WIDTH-1:0] ws, logic [REG_WIDTH-1:0] wd,
                         logic [REG_WIDTH-1:0] wz, pending_word_t p,
                         logic fixed, logic [31:0] value, logic sat);
    directed_row_t row;
    row.ws = ws;
    row.wd = wd;
    row.wz = wz;
    row.entry = p;
    row.entry.fixed = fixed;
    row.entry.want = '{value: value, axis: p.word.axis, kind: p.word.kind, sat: sat};
    directed_q.push_back(row);
  endtask

  function automatic logic [31:0] random_coord(int style);
    logic [31:0] v;
    case (style)
      0: v = $urandom;
      1: begin
        case ($urandom_range(3))
          0: v = Q_MAX;
          1: v = Q_MIN;
          2: v = Q_MAX - 32'($urandom_range(65535));
          default: v = Q_MIN + 32'($urandom_range(65535));
        endcase
      end
      default: v = 32'($urandom_range(32'h3FFFF)) - 32'h1FFFF;
    endcase
    return v;
  endfunction

  // Random word: whole-range, near-extreme, small or mixed corners.
  function automatic pending_word_t random_word();
    pending_word_t p;
    int            style;
    style = $urandom_range(3);
    for (int i = 0; i < 8; i++)
      p.word.corner[i] = random_coord((style == 3) ? int'($urandom_range(2)) : style);
    p.word.axis = ($urandom_range(9) == 0) ? AXIS_NONE : AXIS_WIDTH'($urandom_range(2));
    p.word.kind = ($urandom_range(99) < 15) ? KIND_OFFSET : KIND_VERTEX;
    p.fixed = 1'b0;
    p.want = '0;
    return p;
  endfunction

  function automatic logic [REG_WIDTH-1:0] pick_weight();
    case ($urandom_range(5))
      0: return WEIGHT_ZERO;
      1: return WEIGHT_ONE;
      2: return REG_WIDTH'($urandom_range(int'(WEIGHT_TOP), int'(WEIGHT_ONE) + 1));
      default: return REG_WIDTH'($urandom_range(int'(WEIGHT_ONE)));
    endcase
  endfunction

  function automatic bit take_idle();
    return !steady_run && ($urandom_range(99) < IDLE_PERCENT);
  endfunction

  // Write all three weights back to back, then a spare index that must be ignored.
  task automatic set_weights(logic [REG_WIDTH-1:0] ws, logic [REG_WIDTH-1:0] wd,
                             logic [REG_WIDTH-1:0] wz);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_STRENGTH;
    cfg_data <= ws;
    @(posedge clk);
    cfg_index <= REG_DEXTERITY;
    cfg_data <= wd;
    @(posedge clk);
    cfg_index <= REG_SCALE;
    cfg_data <= wz;
    @(posedge clk);
    cfg_index <= REG_SPARE;
    cfg_data <= REG_WIDTH'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    strength_reg = ws;
    dexterity_reg = wd;
    scale_reg = wz;
  endtask

  // Wait until every word is sent and every result is back, then let the pipe settle.
  task automatic wait_drained();
    while (send_q.size() != 0 || corners_if.valid || blend_results_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic note_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  // Corner sender: records the expectation of each accepted word, then offers the next.
  initial begin
    corners_if.valid = 1'b0;
    corners_if.corner_0 = '0;
    corners_if.corner_1 = '0;
    corners_if.corner_2 = '0;
    corners_if.corner_3 = '0;
    corners_if.corner_4 = '0;
    corners_if.corner_5 = '0;
    corners_if.corner_6 = '0;
    corners_if.corner_7 = '0;
    corners_if.axis = AXIS_X;
    corners_if.item_kind = KIND_VERTEX;
    forever begin
      @(posedge clk);
      if (rst) begin
        corners_if.valid <= 1'b0;
      end else if (!corners_if.valid || corners_if.ready) begin
        if (corners_if.valid) begin
          if (on_bus.fixed) begin
            void'(predict_blend(on_bus.word));
            blend_results_q.push_back(on_bus.want);
          end else begin
            blend_results_q.push_back(predict_blend(on_bus.word));
          end
        end
        if (send_q.size() != 0 && !take_idle()) begin
          on_bus = send_q.pop_front();
          corners_if.valid <= 1'b1;
          corners_if.corner_0 <= on_bus.word.corner[0];
          corners_if.corner_1 <= on_bus.word.corner[1];
          corners_if.corner_2 <= on_bus.word.corner[2];
          corners_if.corner_3 <= on_bus.word.corner[3];
          corners_if.corner_4 <= on_bus.word.corner[4];
          corners_if.corner_5 <= on_bus.word.corner[5];
          corners_if.corner_6 <= on_bus.word.corner[6];
          corners_if.corner_7 <= on_bus.word.corner[7];
          corners_if.axis <= on_bus.word.axis;
          corners_if.item_kind <= on_bus.word.kind;
        end else begin
          corners_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result receiver stalls at random.
  initial begin
    results_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      results_if.ready <= !take_idle();
    end
  end

  // Compare each accepted result word with the oldest expectation.
  always @(posedge clk) begin : result_check
    result_word_t got;
    result_word_t want;
    if (!rst && results_if.valid && results_if.ready) begin
      got.value = results_if.blended_value;
      got.axis = results_if.result_axis;
      got.kind = item_kind_t'(results_if.result_kind);
      got.sat = results_if.saturated;
      if (blend_results_q.size() == 0) begin
        note_failure($sformatf("result %0d: unexpected word value %h axis %0d kind %0d sat %0d",
                               result_count, got.value, got.axis, got.kind, got.sat));
      end else begin
        want = blend_results_q.pop_front();
        if (got.value !== want.value || got.axis !== want.axis ||
            got.kind !== want.kind || got.sat !== want.sat)
          note_failure($sformatf({"result %0d: expected value %h axis %0d kind %0d sat %0d,",
                                  " got value %h axis %0d kind %0d sat %0d"},
                                 result_count, want.value, want.axis, want.kind, want.sat,
                                 got.value, got.axis, got.kind, got.sat));
      end
      result_count++;
    end
  end

  // Watchdog on a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL morph_target_trilinear_blend_top");
      $finish;
    end
  end

  initial begin
    // Weight zero picks corner 0, so the first rows read straight off the inputs.
    add_row(WEIGHT_ZERO, WEIGHT_ZERO, WEIGHT_ZERO, make_word('0, Q_MAX, AXIS_X, KIND_VERTEX),
            1'b1, '0, 1'b0);
    add_row(WEIGHT_ZERO, WEIGHT_ZERO, WEIGHT_ZERO, make_word(Q_MAX, Q_MIN, AXIS_Y, KIND_VERTEX),
            1'b1, Q_MAX, 1'b0);
    add_row(WEIGHT_ZERO, WEIGHT_ZERO, WEIGHT_ZERO, make_word(Q_MIN, Q_MAX, AXIS_Z, KIND_VERTEX),
            1'b1, Q_MIN, 1'b0);
    add_row(WEIGHT_ZERO, WEIGHT_ZERO, WEIGHT_ZERO,
            make_word(32'h7FFF_0000, '0, AXIS_X, KIND_OFFSET), 1'b1, 32'h7FFF_0000, 1'b0);
    // Offset plus one crosses the top by exactly one.
    add_row(WEIGHT_ZERO, WEIGHT_ZERO, WEIGHT_ZERO,
            make_word(32'h0001_0000, '0, AXIS_X, KIND_VERTEX), 1'b1, Q_MAX, 1'b1);
    add_row(WEIGHT_ZERO, WEIGHT_ZERO, WEIGHT_ZERO,
            make_word(32'hFFFF_0000, '0, AXIS_X, KIND_VERTEX), 1'b1, 32'h7FFE_0000, 1'b0);
    add_row(WEIGHT_ZERO, WEIGHT_ZERO, WEIGHT_ZERO, make_word(Q_MIN, Q_MAX, AXIS_Y, KIND_OFFSET),
            1'b1, Q_MIN, 1'b0);
    add_row(WEIGHT_ZERO, WEIGHT_ZERO, WEIGHT_ZERO,
            make_word(32'hFFFF_FFFF, '0, AXIS_Y, KIND_VERTEX), 1'b1, Q_MIN, 1'b1);
    // The unused axis code stores nothing and adds nothing.
    add_row(WEIGHT_ZERO, WEIGHT_ZERO, WEIGHT_ZERO,
            make_word(32'h1234_5678, '0, AXIS_NONE, KIND_OFFSET), 1'b1, 32'h1234_5678, 1'b0);
    add_row(WEIGHT_ZERO, WEIGHT_ZERO, WEIGHT_ZERO,
            make_word(32'h4000_0000, '0, AXIS_NONE, KIND_VERTEX), 1'b1, 32'h4000_0000, 1'b0);
    // A sum of exactly the minimum is not clamped; one below it is.
    add_row(WEIGHT_ZERO, WEIGHT_ZERO, WEIGHT_ZERO,
            make_word(32'hC000_0000, '0, AXIS_Z, KIND_OFFSET), 1'b1, 32'hC000_0000, 1'b0);
    add_row(WEIGHT_ZERO, WEIGHT_ZERO, WEIGHT_ZERO,
            make_word(32'hC000_0000, '0, AXIS_Z, KIND_VERTEX), 1'b1, Q_MIN, 1'b0);
    add_row(WEIGHT_ZERO, WEIGHT_ZERO, WEIGHT_ZERO,
            make_word(32'hBFFF_FFFF, '0, AXIS_Z, KIND_VERTEX), 1'b1, Q_MIN, 1'b1);
    // Weight one picks corner 7.
    add_row(WEIGHT_ONE, WEIGHT_ONE, WEIGHT_ONE, make_word(Q_MIN, Q_MAX, AXIS_X, KIND_VERTEX),
            1'b1, Q_MAX, 1'b1);
    add_row(WEIGHT_ONE, WEIGHT_ONE, WEIGHT_ONE, make_word(Q_MAX, '0, AXIS_X, KIND_OFFSET),
            1'b1, '0, 1'b0);
    add_row(WEIGHT_ONE, WEIGHT_ONE, WEIGHT_ONE, make_word('0, Q_MAX, AXIS_Y, KIND_VERTEX),
            1'b1, 32'hFFFF_FFFF, 1'b0);
    // Weights above one behave as one.
    add_row(WEIGHT_TOP, WEIGHT_ONE + 1'b1, WEIGHT_TOP,
            make_word('0, 32'h5A5A_5A5A, AXIS_X, KIND_VERTEX), 1'b1, 32'h5A5A_5A5A, 1'b0);
    add_row(WEIGHT_TOP, WEIGHT_ONE + 1'b1, WEIGHT_TOP, make_word(Q_MAX, '0, AXIS_Y, KIND_OFFSET),
            1'b1, '0, 1'b0);
    // Midpoints over the full range and floor of negative products.
    add_row(WEIGHT_HALF, WEIGHT_HALF, WEIGHT_HALF, make_word(Q_MIN, Q_MAX, AXIS_X, KIND_VERTEX),
            1'b0, '0, 1'b0);
    add_row(WEIGHT_HALF, WEIGHT_HALF, WEIGHT_HALF, make_word(Q_MAX, Q_MIN, AXIS_Y, KIND_VERTEX),
            1'b0, '0, 1'b0);
    add_row(WEIGHT_HALF, WEIGHT_HALF, WEIGHT_HALF,
            make_word(32'h0000_0001, 32'hFFFF_FFFF, AXIS_Z, KIND_OFFSET), 1'b0, '0, 1'b0);
    add_row(WEIGHT_HALF, WEIGHT_HALF, WEIGHT_HALF,
            make_word(32'hFFFF_FFFF, '0, AXIS_Z, KIND_VERTEX), 1'b0, '0, 1'b0);
    // Uneven weights.
    add_row(17'd1, 17'd65535, 17'd12345, make_word(Q_MIN, Q_MAX, AXIS_X, KIND_VERTEX),
            1'b0, '0, 1'b0);
    add_row(17'd1, 17'd65535, 17'd12345,
            make_word(32'h0003_0000, 32'hFFFD_0000, AXIS_X, KIND_OFFSET), 1'b0, '0, 1'b0);
    add_row(17'd1, 17'd65535, 17'd12345,
            make_word(32'h1357_2468, 32'hECA8_DB97, AXIS_X, KIND_VERTEX), 1'b0, '0, 1'b0);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed table; weights change only with the pipe empty.
    foreach (directed_q[i]) begin
      if (directed_q[i].ws != strength_reg || directed_q[i].wd != dexterity_reg ||
          directed_q[i].wz != scale_reg) begin
        wait_drained();
        set_weights(directed_q[i].ws, directed_q[i].wd, directed_q[i].wz);
      end
      send_q.push_back(directed_q[i].entry);
    end
    wait_drained();

    // Random phases, each with its own weights; one phase runs with no idling.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      set_weights(pick_weight(), pick_weight(), pick_weight());
      steady_run = (phase == 3);
      repeat (PHASE_WORDS) send_q.push_back(random_word());
      wait_drained();
      steady_run = 1'b0;
    end

    if (fail_count == 0) begin
      $display("PASS morph_target_trilinear_blend_top");
    end else begin
      $display("FAIL morph_target_trilinear_blend_top");
    end
    $finish;
  end

endmodule
